/* rtl/core/unr_pkg.sv */
package unr_pkg;

  localparam int WIDTH = 16;
  localparam int REM_WIDTH = WIDTH + 2;

  typedef struct packed {
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } op_t;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
  } res_t;

  // partial remainder, dividend bits still to come sharing a register with
  // quotient bits already made, and the divisor
  typedef struct packed {
    logic signed [REM_WIDTH-1:0] rem;
    logic [WIDTH-1:0]            qd;
    logic [WIDTH-1:0]            divisor;
  } step_t;

endpackage

/* rtl/core/unsigned_nonrestoring_divider.sv */
// Unsigned non-restoring divider: each word on op gives quotient and remainder
// on res. There is one add/subtract stage per quotient bit plus a remainder
// correction stage. Throughput is one word per cycle while res is not stalled;
// a stall at res holds every stage that is full, and empty stages keep filling.
// A zero divisor gives an all-ones quotient and the dividend as remainder.
module unsigned_nonrestoring_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  unr_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_ready,
  output unr_pkg::res_t res
);

  logic           valid [unr_pkg::WIDTH+1];
  logic           ready [unr_pkg::WIDTH+1];
  unr_pkg::step_t data  [unr_pkg::WIDTH+1];

  assign valid[0]        = op_valid;
  assign op_ready        = ready[0];
  assign data[0].rem     = '0;
  assign data[0].qd      = op.dividend;
  assign data[0].divisor = op.divisor;

  for (genvar i = 0; i < unr_pkg::WIDTH; i++) begin : g_step
    unr_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_data  (data[i+1])
    );
  end

  unr_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[unr_pkg::WIDTH]),
    .in_ready  (ready[unr_pkg::WIDTH]),
    .in_data   (data[unr_pkg::WIDTH]),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_data  (res)
  );

endmodule

/* rtl/core/unr_step.sv */
module unr_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  unr_pkg::step_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output unr_pkg::step_t out_data
);

  logic signed [unr_pkg::REM_WIDTH-1:0] shifted;
  logic signed [unr_pkg::REM_WIDTH-1:0] dext;
  unr_pkg::step_t                       data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    shifted = {in_data.rem[unr_pkg::REM_WIDTH-2:0], in_data.qd[unr_pkg::WIDTH-1]};
    dext    = {2'b00, in_data.divisor};
    data_next.divisor = in_data.divisor;
    if (in_data.rem[unr_pkg::REM_WIDTH-1]) begin
      data_next.rem = shifted + dext;
    end else begin
      data_next.rem = shifted - dext;
    end
    data_next.qd = {in_data.qd[unr_pkg::WIDTH-2:0], ~data_next.rem[unr_pkg::REM_WIDTH-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/core/unr_fix.sv */
module unr_fix (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  unr_pkg::step_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output unr_pkg::res_t  out_data
);

  logic signed [unr_pkg::REM_WIDTH-1:0] rem_fixed;
  unr_pkg::res_t                        data_next;

  assign in_ready = !out_valid || out_ready;

  // a negative final remainder takes the divisor back once
  always_comb begin
    if (in_data.rem[unr_pkg::REM_WIDTH-1]) begin
      rem_fixed = in_data.rem + {2'b00, in_data.divisor};
    end else begin
      rem_fixed = in_data.rem;
    end
    data_next.quotient  = in_data.qd;
    data_next.remainder = rem_fixed[unr_pkg::WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
